[rtl/fptw_pkg.sv]
// Shared types, constants and helpers for the four-level page table walker.
package fptw_pkg;

  // Field widths of one request and one response.
  localparam int unsigned OP_W      = 2;
  localparam int unsigned VA_W      = 48;
  localparam int unsigned PA_W      = 52;
  localparam int unsigned FLAGS_W   = 12;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned PAGE_W    = 40;
  localparam int unsigned ENTRY_W   = 64;
  localparam int unsigned IDX_W     = 9;
  localparam int unsigned ENTRIES_PER_TABLE = 512;

  // Packed stream widths, padded to whole bytes.
  localparam int unsigned IN_FIELDS_W  = OP_W + VA_W + PA_W + FLAGS_W;
  localparam int unsigned IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_FIELDS_W = STATUS_W + PA_W + FLAGS_W;
  localparam int unsigned OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Entry flag bit positions.
  localparam int unsigned FLAG_P_BIT = 0;
  localparam int unsigned FLAG_W_BIT = 1;
  localparam int unsigned FLAG_U_BIT = 2;

  // Walk level of the root table; level zero is the leaf.
  localparam logic [1:0] LVL_ROOT = 2'd3;
  localparam logic [1:0] LVL_LEAF = 2'd0;

  // Request operations.
  typedef enum logic [OP_W-1:0] {
    OP_TRANSLATE = 2'd0,
    OP_MAP       = 2'd1,
    OP_UNMAP     = 2'd2,
    OP_CLR_USER  = 2'd3
  } op_t;

  // Response status codes.
  typedef logic [STATUS_W-1:0] status_t;
  localparam status_t ST_OK          = 3'd0;
  localparam status_t ST_NO_TABLE    = 3'd1;
  localparam status_t ST_NOT_PRESENT = 3'd2;
  localparam status_t ST_NOT_USER    = 3'd3;
  localparam status_t ST_MAPPED      = 3'd4;
  localparam status_t ST_OUT_OF_TBL  = 3'd5;
  localparam status_t ST_ZERO_FRAME  = 3'd6;

  // Nine-bit table index of a virtual address at a given level.
  function automatic logic [IDX_W-1:0] level_idx(input logic [VA_W-1:0] va,
                                                 input logic [1:0]      lvl);
    logic [IDX_W-1:0] idx;
    unique case (lvl)
      2'd3:    idx = va[47:39];
      2'd2:    idx = va[38:30];
      2'd1:    idx = va[29:21];
      default: idx = va[20:12];
    endcase
    return idx;
  endfunction

endpackage

[rtl/fptw_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module fptw_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/fptw_alu.sv]
// Shared 40-bit page adder/subtractor with a bound compare.
module fptw_alu
  import fptw_pkg::*;
(
  input  logic              sub,
  input  logic [PAGE_W-1:0] op_a,
  input  logic [PAGE_W-1:0] op_b,
  input  logic [PAGE_W-1:0] bound,
  output logic [PAGE_W-1:0] result,
  output logic              below
);

  // Subtract turns a table pointer into a pool index; add turns an index into a page.
  assign result = sub ? (op_a - op_b) : (op_a + op_b);
  assign below  = (result < bound);

endmodule

[rtl/four_level_page_table_walker_core.sv]
// Top level of the four-level page table walker: sequencer, pool counter and table store.
//
// The block holds NUM_TABLES page tables of 512 64-bit entries in one RAM, table 0 being
// the root, and serves one request per input transaction: translate, map, unmap or clear
// the user bit of one 4 KiB page. After reset it first sweeps the whole store to zero, one
// entry per cycle, and takes no request during that sweep (configuration writes are taken
// at any time). A request then passes, for each table level it reads, through a state that
// addresses the RAM and a state that checks the registered entry through the shared 40-bit
// page adder, and then through a state that moves the result into the output register once
// that register is free; a walk that stops early reads fewer levels. A map creates a missing
// table in the check state itself, with no extra state. The input is ready only when the
// walker is idle, so a new request is taken only after the last one is done; a finished
// response sits in an output register, so the next request is accepted while it waits to be
// taken.
module four_level_page_table_walker_core
  import fptw_pkg::*;
#(
  parameter int unsigned NUM_TABLES = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration: table_pool_base_page.
  input  logic                  cfg_wr_en,
  input  logic [PAGE_W-1:0]     cfg_wr_data,
  // Request stream.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // Fields from bit 0 up: operation[2], virt_addr[48], phys_addr[52], perm[12], zero pad.
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // Response stream.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // Fields from bit 0 up: status[3], phys_page_out[52], entry_flags[12], zero pad.
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int unsigned Depth = NUM_TABLES * ENTRIES_PER_TABLE;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned TW    = $clog2(NUM_TABLES);
  localparam int unsigned CW    = $clog2(NUM_TABLES + 1);
  localparam logic [AW-1:0] AddrLast = AW'(Depth - 1);
  localparam logic [CW-1:0] CntFull  = CW'(NUM_TABLES);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CHECK,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  // Control state.
  logic [AW-1:0]      clr_cnt_r, clr_cnt_nxt;
  logic [CW-1:0]      nft_r, nft_nxt;
  logic [PAGE_W-1:0]  base_r, base_nxt;
  logic [1:0]         lvl_r, lvl_nxt;
  logic [TW-1:0]      tbl_r, tbl_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Request and result payload.
  op_t                op_r, op_nxt;
  logic [VA_W-1:0]    va_r, va_nxt;
  logic [PA_W-1:0]    pa_r, pa_nxt;
  logic [FLAGS_W-1:0] perm_r, perm_nxt;
  status_t            res_status_r, res_status_nxt;
  logic [PA_W-1:0]    res_phys_r, res_phys_nxt;
  logic [FLAGS_W-1:0] res_flags_r, res_flags_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [PA_W-1:0]    out_phys_r, out_phys_nxt;
  logic [FLAGS_W-1:0] out_flags_r, out_flags_nxt;

  // Table store signals.
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [AW-1:0]      walk_addr;
  logic [ENTRY_W-1:0] entry;

  // Shared adder signals.
  logic               alu_sub;
  logic [PAGE_W-1:0]  alu_a;
  logic [PAGE_W-1:0]  alu_b;
  logic [PAGE_W-1:0]  alu_res;
  logic               alu_below;
  logic               ent_present;

  assign walk_addr   = {tbl_r, level_idx(va_r, lvl_r)};
  assign ent_present = entry[FLAG_P_BIT];

  fptw_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (Depth)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (walk_addr),
    .rdata (entry)
  );

  // Present entry: page minus base gives the pool index; absent: base plus count gives
  // the page of the table about to be created.
  assign alu_sub = ent_present;
  assign alu_a   = ent_present ? entry[51:12] : base_r;
  assign alu_b   = ent_present ? base_r : PAGE_W'(nft_r);

  fptw_alu u_alu (
    .sub    (alu_sub),
    .op_a   (alu_a),
    .op_b   (alu_b),
    .bound  (PAGE_W'(nft_r)),
    .result (alu_res),
    .below  (alu_below)
  );

  // Sequencer next-state logic.
  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    nft_nxt        = nft_r;
    base_nxt       = base_r;
    lvl_nxt        = lvl_r;
    tbl_nxt        = tbl_r;
    out_valid_nxt  = out_valid_r;
    op_nxt         = op_r;
    va_nxt         = va_r;
    pa_nxt         = pa_r;
    perm_nxt       = perm_r;
    res_status_nxt = res_status_r;
    res_phys_nxt   = res_phys_r;
    res_flags_nxt  = res_flags_r;
    out_status_nxt = out_status_r;
    out_phys_nxt   = out_phys_r;
    out_flags_nxt  = out_flags_r;
    ram_we         = 1'b0;
    ram_waddr      = walk_addr;
    ram_wdata      = '0;

    if (cfg_wr_en) begin
      base_nxt = cfg_wr_data;
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        if (clr_cnt_r == AddrLast) begin
          state_nxt = S_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + AW'(1);
        end
      end

      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt         = op_t'(in_tdata[1:0]);
          va_nxt         = in_tdata[49:2];
          pa_nxt         = in_tdata[101:50];
          perm_nxt       = in_tdata[113:102];
          lvl_nxt        = LVL_ROOT;
          tbl_nxt        = '0;
          res_status_nxt = ST_OK;
          res_phys_nxt   = '0;
          res_flags_nxt  = '0;
          state_nxt      = S_READ;
        end
      end

      S_READ: begin
        state_nxt = S_CHECK;
      end

      S_CHECK: begin
        if (lvl_r != LVL_LEAF) begin
          // Intermediate level: follow the pointer or create a table.
          if (ent_present) begin
            if (alu_below) begin
              tbl_nxt   = alu_res[TW-1:0];
              lvl_nxt   = lvl_r - 2'd1;
              state_nxt = S_READ;
            end else begin
              res_status_nxt = ST_NO_TABLE;
              state_nxt      = S_DONE;
            end
          end else if (op_r != OP_MAP) begin
            res_status_nxt = ST_NO_TABLE;
            state_nxt      = S_DONE;
          end else if (nft_r == CntFull) begin
            res_status_nxt = ST_OUT_OF_TBL;
            state_nxt      = S_DONE;
          end else begin
            ram_we    = 1'b1;
            ram_wdata = {12'd0, alu_res, 9'd0, 3'b111};
            tbl_nxt   = nft_r[TW-1:0];
            nft_nxt   = nft_r + CW'(1);
            lvl_nxt   = lvl_r - 2'd1;
            state_nxt = S_READ;
          end
        end else begin
          // Leaf level: apply the operation.
          res_flags_nxt = entry[FLAGS_W-1:0];
          state_nxt     = S_DONE;
          unique case (op_r)
            OP_TRANSLATE: begin
              if (!ent_present) begin
                res_status_nxt = ST_NOT_PRESENT;
              end else if (!entry[FLAG_U_BIT]) begin
                res_status_nxt = ST_NOT_USER;
              end else begin
                res_phys_nxt = {entry[51:12], 12'd0};
              end
            end
            OP_MAP: begin
              if (ent_present) begin
                res_status_nxt = ST_MAPPED;
              end else begin
                ram_we    = 1'b1;
                ram_wdata = {12'd0, pa_r[51:12], perm_r | FLAGS_W'(1)};
              end
            end
            OP_UNMAP: begin
              if (!ent_present) begin
                res_status_nxt = ST_NOT_PRESENT;
              end else if (entry[51:12] == '0) begin
                res_status_nxt = ST_ZERO_FRAME;
              end else begin
                res_phys_nxt = {entry[51:12], 12'd0};
                ram_we       = 1'b1;
                ram_wdata    = '0;
              end
            end
            OP_CLR_USER: begin
              ram_we    = 1'b1;
              ram_wdata = entry & ~(ENTRY_W'(1) << FLAG_U_BIT);
            end
            default: begin
              res_status_nxt = ST_OK;
            end
          endcase
        end
      end

      S_DONE: begin
        // Hand the result over once the output register is free.
        if (!out_valid_r || out_tready) begin
          out_status_nxt = res_status_r;
          out_phys_nxt   = res_phys_r;
          out_flags_nxt  = res_flags_r;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, counters and registered outputs.
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    va_r         <= va_nxt;
    pa_r         <= pa_nxt;
    perm_r       <= perm_nxt;
    lvl_r        <= lvl_nxt;
    tbl_r        <= tbl_nxt;
    res_status_r <= res_status_nxt;
    res_phys_r   <= res_phys_nxt;
    res_flags_r  <= res_flags_nxt;
    out_status_r <= out_status_nxt;
    out_phys_r   <= out_phys_nxt;
    out_flags_r  <= out_flags_nxt;
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      nft_r       <= CW'(1);
      base_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      nft_r       <= nft_nxt;
      base_r      <= base_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - OUT_FIELDS_W)'(0), out_flags_r, out_phys_r, out_status_r};

endmodule
